>>> rtl/mfbp_pkg.sv
// Package for the MSB-first bit packer: request codes, controller states
// and shared constants. No dependencies.
`timescale 1ns / 1ps

package mfbp_pkg;

   // Request codes carried on req_req_type.
   localparam logic [2:0] REQ_WRITE  = 3'd0;
   localparam logic [2:0] REQ_SKIP   = 3'd1;
   localparam logic [2:0] REQ_REWIND = 3'd2;
   localparam logic [2:0] REQ_CLEAR  = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;

   // Configuration register index of max_bits, decoded from paddr[2].
   localparam logic CSR_MAX_BITS = 1'b0;

   localparam logic [15:0] MAX_BITS_RESET = 16'd32768;
   localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
   localparam logic [16:0] FIELD_MAX      = 17'd32;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_CLEAR
   } state_type;

endpackage

>>> rtl/msb_first_bit_packer.sv
// MSB-first bit packer top level: request channel, response channel,
// APB-style register port and two word banks. Depends on mfbp_pkg.
`timescale 1ns / 1ps

// Usage: each request transaction (write field, skip, rewind, clear, read)
// yields exactly one response transaction with ok, bits_written and
// read_data. The store is split into an even-word bank and an odd-word
// bank, so a field that straddles two words is merged in one
// read-modify-write pass. Accepted writes and all reads do a bank read,
// then pass through the access state (merge and write back, or select
// the read word); skip, rewind, refused writes and unknown requests load
// their response when they are accepted. No new request is taken while a
// write or read is in its access state; skips, rewinds and refused requests
// can be taken one per cycle while rsp_ready is high. Clear sweeps both
// banks at one address per cycle and answers when the sweep is done.
// After reset the same clearing pass runs with req_ready low; register
// writes are taken throughout. max_bits resets to 32768. A response waits
// in the output register while rsp_ready is low, and a new request is
// taken only when that register is empty or being emptied in the same cycle.
module msb_first_bit_packer #(
   parameter int WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_req_type,
   input  logic [31:0] req_value,
   input  logic [15:0] req_count,
   input  logic [9:0]  req_word_index,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [15:0] rsp_bits_written,
   output logic [31:0] rsp_read_data,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Bank geometry: even words in bank 0, odd words in bank 1.
   localparam int B0_DEPTH = (WORDS + 1) / 2;
   localparam int B1_USED  = WORDS / 2;
   localparam int B1_DEPTH = (B1_USED > 0) ? B1_USED : 1;
   localparam int BAW      = (B0_DEPTH > 1) ? $clog2(B0_DEPTH) : 1;
   localparam logic [16:0] WORDS_W   = 17'(WORDS);
   localparam logic [16:0] B1_USED_W = 17'(B1_USED);
   localparam logic [BAW-1:0] SWEEP_LAST = BAW'(B0_DEPTH - 1);

   logic [31:0] bank0_mem [B0_DEPTH];
   logic [31:0] bank1_mem [B1_DEPTH];

   mfbp_pkg::state_type state_ff, state_in;

   logic [15:0]    fill_ff, fill_in;
   logic [15:0]    max_bits_ff, max_bits_in;
   logic [BAW-1:0] sweep_ff, sweep_in;
   logic           clr_rsp_ff, clr_rsp_in;

   // Captured work for the access cycle.
   logic           op_read_ff, op_read_in;
   logic [31:0]    hi_ff, hi_in;
   logic [31:0]    lo_ff, lo_in;
   logic           par_ff, par_in;
   logic           en_hi_ff, en_hi_in;
   logic           en_lo_ff, en_lo_in;
   logic           rsel_ff, rsel_in;
   logic           rvalid_ff, rvalid_in;
   logic [BAW-1:0] addr0_ff, addr0_in;
   logic [BAW-1:0] addr1_ff, addr1_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [15:0]    rsp_bits_ff, rsp_bits_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;

   // Bank ports.
   logic [31:0]    rd0_ff, rd1_ff;
   logic           re;
   logic [BAW-1:0] ra0, ra1, wa0, wa1;
   logic           we0, we1;
   logic [31:0]    wd0, wd1;

   // Decode helpers for the current request.
   logic           req_accept;
   logic [10:0]    wp;
   logic [11:0]    wp_next;
   logic [4:0]     bo;
   logic [16:0]    fill_sum;
   logic           fits;
   logic [31:0]    mask;
   logic [6:0]     shamt;
   logic [63:0]    window;
   logic           csr_write;

   assign req_ready  = (state_ff == mfbp_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_bits_written = rsp_bits_ff;
   assign rsp_read_data    = rsp_data_ff;

   // Register port: a write lands in the access phase; reads are immediate.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == mfbp_pkg::CSR_MAX_BITS) ?
                       {16'd0, max_bits_ff} : 32'd0;

   // Position and field placement in a two-word window.
   assign wp       = fill_ff[15:5];
   assign bo       = fill_ff[4:0];
   assign wp_next  = {1'b0, wp} + 12'd1;
   assign fill_sum = {1'b0, fill_ff} + {1'b0, req_count};
   assign fits     = fill_sum <= {1'b0, max_bits_ff};
   assign mask     = ~(mfbp_pkg::ALL_ONES << req_count[5:0]);
   assign shamt    = 7'd64 - {2'b00, bo} - req_count[6:0];
   assign window   = {32'd0, req_value & mask} << shamt;

   // Bank read addresses, sampled when a request is taken.
   assign re = req_accept;
   always_comb begin
      if (req_req_type == mfbp_pkg::REQ_READ) begin
         ra0 = BAW'(req_word_index[9:1]);
         ra1 = BAW'(req_word_index[9:1]);
      end else begin
         ra0 = BAW'(wp_next[11:1]);
         ra1 = BAW'(wp[10:1]);
      end
   end

   // Bank write ports: merge in the access cycle, zero during a sweep.
   always_comb begin
      we0 = 1'b0;
      we1 = 1'b0;
      wa0 = addr0_ff;
      wa1 = addr1_ff;
      wd0 = rd0_ff | (par_ff ? lo_ff : hi_ff);
      wd1 = rd1_ff | (par_ff ? hi_ff : lo_ff);
      if (state_ff == mfbp_pkg::ST_ACCESS && !op_read_ff) begin
         we0 = par_ff ? en_lo_ff : en_hi_ff;
         we1 = par_ff ? en_hi_ff : en_lo_ff;
      end else if (state_ff == mfbp_pkg::ST_CLEAR) begin
         wa0 = sweep_ff;
         wa1 = sweep_ff;
         wd0 = 32'd0;
         wd1 = 32'd0;
         we0 = 1'b1;
         we1 = 17'(sweep_ff) < B1_USED_W;
      end
   end

   // Word banks with registered read data.
   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_mem[wa0] <= wd0;
      end
      if (re) begin
         rd0_ff <= bank0_mem[ra0];
      end
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_mem[wa1] <= wd1;
      end
      if (re) begin
         rd1_ff <= bank1_mem[ra1];
      end
   end

   // Next state, position and response.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      max_bits_in = max_bits_ff;
      sweep_in    = sweep_ff;
      clr_rsp_in  = clr_rsp_ff;
      op_read_in  = op_read_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      par_in      = par_ff;
      en_hi_in    = en_hi_ff;
      en_lo_in    = en_lo_ff;
      rsel_in     = rsel_ff;
      rvalid_in   = rvalid_ff;
      addr0_in    = addr0_ff;
      addr1_in    = addr1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write && csr_paddr[2] == mfbp_pkg::CSR_MAX_BITS) begin
         max_bits_in = csr_pwdata[15:0];
      end

      unique case (state_ff)
         mfbp_pkg::ST_IDLE: begin
            if (req_accept) begin
               // Defaults for a transaction whose response is loaded at acceptance.
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_data_in  = 32'd0;
               hi_in        = window[63:32];
               lo_in        = window[31:0];
               par_in       = wp[0];
               en_hi_in     = (req_count != 16'd0) && ({6'd0, wp} < WORDS_W);
               en_lo_in     = (req_count != 16'd0) && ({5'd0, wp_next} < WORDS_W);
               rsel_in      = req_word_index[0];
               rvalid_in    = {7'd0, req_word_index} < WORDS_W;
               addr0_in     = ra0;
               addr1_in     = ra1;
               unique case (req_req_type)
                  mfbp_pkg::REQ_WRITE: begin
                     if ({1'b0, req_count} <= mfbp_pkg::FIELD_MAX && fits) begin
                        fill_in      = fill_sum[15:0];
                        op_read_in   = 1'b0;
                        rsp_valid_in = 1'b0;
                        state_in     = mfbp_pkg::ST_ACCESS;
                     end else begin
                        rsp_ok_in = 1'b0;
                     end
                  end
                  mfbp_pkg::REQ_SKIP: begin
                     if (fits) begin
                        fill_in = fill_sum[15:0];
                     end else begin
                        rsp_ok_in = 1'b0;
                     end
                  end
                  mfbp_pkg::REQ_REWIND: begin
                     fill_in = 16'd0;
                  end
                  mfbp_pkg::REQ_CLEAR: begin
                     fill_in      = 16'd0;
                     rsp_valid_in = 1'b0;
                     clr_rsp_in   = 1'b1;
                     sweep_in     = '0;
                     state_in     = mfbp_pkg::ST_CLEAR;
                  end
                  mfbp_pkg::REQ_READ: begin
                     op_read_in   = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = mfbp_pkg::ST_ACCESS;
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
               rsp_bits_in = fill_in;
            end
         end
         mfbp_pkg::ST_ACCESS: begin
            // The output register is free here: it was free at acceptance.
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_bits_in  = fill_ff;
            if (op_read_ff && rvalid_ff) begin
               rsp_data_in = rsel_ff ? rd1_ff : rd0_ff;
            end else begin
               rsp_data_in = 32'd0;
            end
            state_in = mfbp_pkg::ST_IDLE;
         end
         mfbp_pkg::ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in   = mfbp_pkg::ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_bits_in  = fill_ff;
                  rsp_data_in  = 32'd0;
               end
            end
         end
         default: begin
            state_in = mfbp_pkg::ST_IDLE;
         end
      endcase
   end

   // State register; reset starts a clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfbp_pkg::ST_CLEAR;
         fill_ff      <= 16'd0;
         max_bits_ff  <= mfbp_pkg::MAX_BITS_RESET;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         max_bits_ff  <= max_bits_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_read_ff  <= op_read_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      par_ff      <= par_in;
      en_hi_ff    <= en_hi_in;
      en_lo_ff    <= en_lo_in;
      rsel_ff     <= rsel_in;
      rvalid_ff   <= rvalid_in;
      addr0_ff    <= addr0_in;
      addr1_ff    <= addr1_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A read transaction is answered once its access state has passed.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_req_type == mfbp_pkg::REQ_READ) |-> ##2 rsp_valid_ff)
      else $error("read response missing two cycles after acceptance");

   // The banks are only written during a merge or a sweep.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfbp_pkg::ST_IDLE) |-> !(we0 || we1))
      else $error("bank written while idle");

   // A new transaction never overruns a pending response.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!rsp_valid_ff || rsp_ready))
      else $error("request accepted over a pending response");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the MSB-first bit packer: directed field, capacity and
// store-boundary cases, then random request streams under stalls. Depends on mfbp_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int STORE_WORDS = 1024;
   localparam logic [2:0] MAX_BITS_ADDR = {mfbp_pkg::CSR_MAX_BITS, 2'b00};
   // Request codes with no meaning in the block.
   localparam logic [2:0] REQ_BAD_LO = 3'd5;
   localparam logic [2:0] REQ_BAD_HI = 3'd7;

   typedef struct packed {
      logic        ok;
      logic [15:0] bits_written;
      logic [31:0] read_data;
   } pack_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_req_type;
   logic [31:0] req_value;
   logic [15:0] req_count;
   logic [9:0]  req_word_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_ok;
   logic [15:0] rsp_bits_written;
   logic [31:0] rsp_read_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted block state.
   logic [31:0]     packed_image [STORE_WORDS];
   logic [15:0]     fill_bits;
   logic [15:0]     capacity_bits;
   pack_result_type pending_rsps [$];
   int              mismatch_count;
   int              hold_cycles;
   bit              quiet_run;

   msb_first_bit_packer #(.WORDS(STORE_WORDS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_req_type(req_req_type),
      .req_value(req_value),
      .req_count(req_count),
      .req_word_index(req_word_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_bits_written(rsp_bits_written),
      .rsp_read_data(rsp_read_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Upper bound on the whole run.
   initial begin
      #5_000_000;
      $display("** msb_first_bit_packer: FAILED **");
      $finish;
   end

   // ORs bits into one word of the image; words past the store are dropped.
   function automatic void or_image_word(input int unsigned idx, input logic [31:0] bits);
      if (idx < STORE_WORDS) begin
         packed_image[idx] |= bits;
      end
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic pack_result_type pack_predict(input logic [2:0] kind,
                                                    input logic [31:0] value,
                                                    input logic [15:0] count,
                                                    input logic [9:0] index);
      pack_result_type r;
      int unsigned     next_fill;
      int unsigned     space;
      int unsigned     spill;
      int unsigned     wp;
      logic [31:0]     mask;
      logic [31:0]     field;
      r = '0;
      next_fill = int'(fill_bits) + int'(count);
      case (kind)
         mfbp_pkg::REQ_WRITE: begin
            if (count <= mfbp_pkg::FIELD_MAX && next_fill <= capacity_bits) begin
               mask = (count == mfbp_pkg::FIELD_MAX) ? mfbp_pkg::ALL_ONES
                                                     : ((32'd1 << count) - 32'd1);
               field = value & mask;
               space = 32 - (fill_bits % 32);
               wp = fill_bits / 32;
               if (count != 0) begin
                  if (count <= space) begin
                     or_image_word(wp, field << (space - count));
                  end else begin
                     // The field straddles into the next word.
                     spill = count - space;
                     or_image_word(wp, field >> spill);
                     or_image_word(wp + 1, field << (32 - spill));
                  end
               end
               fill_bits = 16'(next_fill);
               r.ok = 1'b1;
            end
         end
         mfbp_pkg::REQ_SKIP: begin
            if (next_fill <= capacity_bits) begin
               fill_bits = 16'(next_fill);
               r.ok = 1'b1;
            end
         end
         mfbp_pkg::REQ_REWIND: begin
            fill_bits = '0;
            r.ok = 1'b1;
         end
         mfbp_pkg::REQ_CLEAR: begin
            fill_bits = '0;
            foreach (packed_image[i]) packed_image[i] = '0;
            r.ok = 1'b1;
         end
         mfbp_pkg::REQ_READ: begin
            r.read_data = packed_image[index];
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.bits_written = fill_bits;
      return r;
   endfunction

   // Offers one request transaction and records its expected response on acceptance.
   task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
                               input logic [15:0] count, input logic [9:0] index);
      int gap;
      @(negedge clock);
      gap = (!quiet_run && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_req_type   <= kind;
      req_value      <= value;
      req_count      <= count;
      req_word_index <= index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsps.push_back(pack_predict(kind, value, count, index));
   endtask

   // Stops offering and waits until every expected response has arrived.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // One register access in two phases; a read is checked against the expected value.
   task automatic csr_access(input logic write, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= MAX_BITS_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (!write && csr_prdata !== data) begin
         $display("%0t: max_bits read expected %h actual %h", $time, data, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Sets the capacity and reads it back.
   task automatic set_capacity(input logic [15:0] bits);
      csr_access(1'b1, {16'd0, bits});
      capacity_bits = bits;
      csr_access(1'b0, {16'd0, bits});
   endtask

   // One random request, weighted toward field writes near the current position.
   task automatic send_random_request();
      int unsigned pick;
      logic [2:0]  kind;
      logic [31:0] value;
      logic [15:0] count;
      logic [9:0]  index;
      value = ($urandom_range(0, 7) == 0) ? mfbp_pkg::ALL_ONES : $urandom;
      count = '0;
      index = 10'($urandom_range(0, STORE_WORDS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         kind = mfbp_pkg::REQ_WRITE;
         count = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(33, 65535))
                                              : 16'($urandom_range(0, 32));
      end else if (pick < 74) begin
         kind = mfbp_pkg::REQ_SKIP;
         pick = $urandom_range(0, 9);
         if (pick < 7) count = 16'($urandom_range(0, 48));
         else if (pick < 9) count = 16'($urandom_range(49, 2000));
         else count = 16'($urandom);
      end else if (pick < 88) begin
         kind = mfbp_pkg::REQ_READ;
         if ($urandom_range(0, 3) != 0) index = 10'((fill_bits >> 5) - $urandom_range(0, 2));
      end else if (pick < 91) begin
         kind = mfbp_pkg::REQ_REWIND;
      end else if (pick < 92) begin
         kind = mfbp_pkg::REQ_CLEAR;
      end else if (pick < 96) begin
         kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      end else begin
         // Field that ends exactly on a word boundary.
         kind = mfbp_pkg::REQ_WRITE;
         count = 16'(32 - (fill_bits % 32));
      end
      send_request(kind, value, count, index);
   endtask

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_cycles = 0;
         end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 29)) @(negedge clock);
         end
      end
   end

   // Compares each response transaction with the oldest expectation.
   always @(posedge clock) begin
      pack_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response ok=%0b bits_written=%0d read_data=%h",
                     $time, rsp_ok, rsp_bits_written, rsp_read_data);
            mismatch_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
               mismatch_count++;
            end
            if (rsp_bits_written !== want.bits_written) begin
               $display("%0t: bits_written expected %0d actual %0d",
                        $time, want.bits_written, rsp_bits_written);
               mismatch_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, want.read_data, rsp_read_data);
               mismatch_count++;
            end
         end
      end
   end

   // Field widths at their extremes, masking, straddling, rewind and clear.
   task automatic test_field_edges();
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd0, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'h0000_0001, 16'd1, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd32, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'hFFFF_FFF5, 16'd4, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd33, '0);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'd27, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'hA5A5_5A5A, 16'd32, '0);
      send_request(mfbp_pkg::REQ_READ, '0, '0, 10'd0);
      send_request(mfbp_pkg::REQ_READ, '0, '0, 10'd1);
      send_request(REQ_BAD_LO, mfbp_pkg::ALL_ONES, 16'd8, 10'd1023);
      send_request(mfbp_pkg::REQ_REWIND, '0, '0, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'h0000_000F, 16'd8, '0);
      send_request(mfbp_pkg::REQ_READ, '0, '0, 10'd0);
      send_request(mfbp_pkg::REQ_CLEAR, '0, '0, '0);
      send_request(mfbp_pkg::REQ_READ, '0, '0, 10'd2);
      wait_for_responses();
   endtask

   // Capacity of zero, then a field that lands exactly on the capacity.
   task automatic test_capacity();
      set_capacity(16'd0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd1, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd0, '0);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'd1, '0);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'hFFFF, '0);
      wait_for_responses();
      set_capacity(16'd40);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'd8, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'h8000_0001, 16'd32, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd1, '0);
      wait_for_responses();
   endtask

   // Bits that fall past the last word are dropped while the position advances.
   task automatic test_store_end();
      set_capacity(16'hFFFF);
      send_request(mfbp_pkg::REQ_REWIND, '0, '0, '0);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'd32760, '0);
      send_request(mfbp_pkg::REQ_WRITE, 32'h0000_FFFF, 16'd16, '0);
      send_request(mfbp_pkg::REQ_READ, '0, '0, 10'd1023);
      send_request(mfbp_pkg::REQ_SKIP, '0, 16'd32754, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd5, '0);
      send_request(mfbp_pkg::REQ_WRITE, mfbp_pkg::ALL_ONES, 16'd1, '0);
      wait_for_responses();
   endtask

   // A stretch of random requests under one capacity setting.
   task automatic test_random_phase(input int items, input logic [15:0] bits);
      set_capacity(bits);
      repeat (items) send_random_request();
      wait_for_responses();
   endtask

   // The response side holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_cycles = 150;
      repeat (20) send_random_request();
      wait_for_responses();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_req_type   = mfbp_pkg::REQ_WRITE;
      req_value      = '0;
      req_count      = '0;
      req_word_index = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      hold_cycles    = 0;
      quiet_run      = 1'b0;
      fill_bits      = '0;
      capacity_bits  = mfbp_pkg::MAX_BITS_RESET;
      foreach (packed_image[i]) packed_image[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The register port works during the clearing pass after reset.
      csr_access(1'b0, {16'd0, mfbp_pkg::MAX_BITS_RESET});
      set_capacity(mfbp_pkg::MAX_BITS_RESET);

      test_field_edges();
      test_capacity();
      test_store_end();
      test_random_phase(250, mfbp_pkg::MAX_BITS_RESET);
      test_random_phase(200, 16'($urandom_range(200, 4000)));
      test_random_phase(200, 16'hFFFF);
      test_random_phase(150, 16'd64);
      test_backpressure();
      quiet_run = 1'b1;
      test_random_phase(200, mfbp_pkg::MAX_BITS_RESET);

      wait_for_responses();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** msb_first_bit_packer: PASSED **");
      end else begin
         $display("** msb_first_bit_packer: FAILED **");
      end
      $finish;
   end

endmodule
